/* design/csec_pkg.sv */
// ----------------------------------------------------------------------------
// csec_pkg: shared types and constants of the configurable SEC codec
// Holds the fixed field widths, the command and status codes, the register
// file type, and the result item that the codec core hands to the top level.
// ----------------------------------------------------------------------------
package csec_pkg;

  // Fixed field widths of the item ports.
  localparam int unsigned WordW     = 32;
  localparam int unsigned CheckW    = 8;
  localparam int unsigned StatusW   = 2;

  // Check-row register file: eight rows, indexed by a 4-bit write index so
  // that writes beyond the last row can be seen and dropped.
  localparam int unsigned RowCount  = 8;
  localparam int unsigned RowIdxW   = 3;
  localparam int unsigned CfgIndexW = 4;

  // Operation carried by each input item.
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_CHECK  = 1'b1
  } csec_cmd_e;

  // Outcome of a check.
  typedef enum logic [StatusW-1:0] {
    STATUS_CLEAN     = 2'd0,
    STATUS_CORRECTED = 2'd1,
    STATUS_UNCORR    = 2'd2
  } csec_status_e;

  typedef logic [RowCount-1:0][WordW-1:0] row_array_t;

  // One result item.
  typedef struct packed {
    logic [WordW-1:0]  data_out;
    logic [CheckW-1:0] check_out;
    logic [CheckW-1:0] syndrome;
    csec_status_e      status;
  } csec_result_t;

  // Mask with the low `count` bits of a check byte set.
  function automatic logic [CheckW-1:0] check_mask(input int unsigned count);
    logic [CheckW-1:0] mask;
    mask = '0;
    for (int unsigned r = 0; r < CheckW; r++) begin
      mask[r] = (r < count);
    end
    return mask;
  endfunction

  // Mask with the low `count` bits of a data word set.
  function automatic logic [WordW-1:0] word_mask(input int unsigned count);
    logic [WordW-1:0] mask;
    mask = '0;
    for (int unsigned i = 0; i < WordW; i++) begin
      mask[i] = (i < count);
    end
    return mask;
  endfunction

endpackage

/* design/csec_core.sv */
// ----------------------------------------------------------------------------
// csec_core: combinational encode / check-and-correct datapath
// Computes check bits from the configured rows, forms the syndrome, matches
// it against the data columns and then the check-bit unit vectors, and
// builds the corrected result item.
// ----------------------------------------------------------------------------
module csec_core #(
  parameter int unsigned PARITY_BITS = 7,
  parameter int unsigned DATA_BITS   = 32
) (
  input  csec_pkg::row_array_t              rows_i,
  input  csec_pkg::csec_cmd_e               cmd_i,
  input  logic [csec_pkg::WordW-1:0]        data_i,
  input  logic [csec_pkg::CheckW-1:0]       rcv_i,
  output csec_pkg::csec_result_t            result_o
);

  localparam logic [csec_pkg::CheckW-1:0] CheckMask = csec_pkg::check_mask(PARITY_BITS);
  localparam logic [csec_pkg::WordW-1:0]  WordMask  = csec_pkg::word_mask(DATA_BITS);

  logic [csec_pkg::CheckW-1:0] calc;
  logic [csec_pkg::CheckW-1:0] rcv_masked;
  logic [csec_pkg::CheckW-1:0] syn;
  logic [csec_pkg::WordW-1:0]  col_match;
  logic [csec_pkg::WordW-1:0]  data_flip;
  logic                        data_hit;
  logic                        unit_hit;
  logic [csec_pkg::CheckW-1:0] check_flip;

  // Recompute the check bits: each is the parity of the data under its row.
  always_comb begin
    for (int unsigned r = 0; r < csec_pkg::CheckW; r++) begin
      calc[r] = CheckMask[r] & (^(data_i & rows_i[r] & WordMask));
    end
  end

  // The syndrome exists only in check mode.
  assign rcv_masked = rcv_i & CheckMask;
  assign syn        = (cmd_i == csec_pkg::CMD_CHECK) ? (rcv_masked ^ calc) : '0;

  // Compare the syndrome with every data column in parallel.
  always_comb begin
    logic [csec_pkg::CheckW-1:0] col;
    for (int unsigned i = 0; i < csec_pkg::WordW; i++) begin
      for (int unsigned r = 0; r < csec_pkg::CheckW; r++) begin
        col[r] = rows_i[r][i] & CheckMask[r];
      end
      col_match[i] = WordMask[i] && (syn != '0) && (col == syn);
    end
  end

  // The lowest matching data bit wins.
  assign data_flip = col_match & (~col_match + csec_pkg::WordW'(1));
  assign data_hit  = |col_match;

  // Otherwise a single set syndrome bit points at a check bit.
  assign unit_hit   = !data_hit && (syn != '0) &&
                      ((syn & (syn - csec_pkg::CheckW'(1))) == '0);
  assign check_flip = unit_hit ? syn : '0;

  // Assemble the result item.
  always_comb begin
    result_o.data_out  = data_i ^ data_flip;
    result_o.check_out = (cmd_i == csec_pkg::CMD_CHECK) ? (rcv_masked ^ check_flip) : calc;
    result_o.syndrome  = syn;
    if (syn == '0) begin
      result_o.status = csec_pkg::STATUS_CLEAN;
    end else if (data_hit || unit_hit) begin
      result_o.status = csec_pkg::STATUS_CORRECTED;
    end else begin
      result_o.status = csec_pkg::STATUS_UNCORR;
    end
  end

endmodule

/* design/configurable_sec_ecc_codec.sv */
// ----------------------------------------------------------------------------
// configurable_sec_ecc_codec: single-error-correcting codec with programmable
// parity-check rows
// Input register, one combinational encode/check pass, result register.
// ----------------------------------------------------------------------------
// Usage:
//   The config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes check row 0..7; ready is always high and writes to an index of
//   eight or more are dropped. Rows must be changed only while no item is
//   in flight; the block itself does not enforce this.
//   Each input item (cmd_i, data_in_i, received_check_i) either encodes a
//   data word or checks and corrects it, and produces exactly one result
//   item (data_out_o, check_out_o, syndrome_o, status_o).
//   An accepted item passes through the input register and then the result
//   register before it is presented on the output.
//   Throughput is one item per cycle unless the receiver stalls, set by the
//   single pass of XOR trees and column compares between the two registers.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; in_ready_o falls only when
//   both are full. Reset clears the rows to zero and empties both stages.
// ----------------------------------------------------------------------------
module configurable_sec_ecc_codec #(
  parameter int unsigned PARITY_BITS = 7,
  parameter int unsigned DATA_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csec_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [csec_pkg::WordW-1:0]        cfg_data_i,
  // Input item channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [csec_pkg::WordW-1:0]        data_in_i,
  input  logic [csec_pkg::CheckW-1:0]       received_check_i,
  // Result item channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [csec_pkg::WordW-1:0]        data_out_o,
  output logic [csec_pkg::CheckW-1:0]       check_out_o,
  output logic [csec_pkg::CheckW-1:0]       syndrome_o,
  output logic [csec_pkg::StatusW-1:0]      status_o
);

  localparam logic [csec_pkg::CheckW-1:0] CheckMask = csec_pkg::check_mask(PARITY_BITS);

  csec_pkg::row_array_t          rows_q;
  logic                          s1_valid_q;
  csec_pkg::csec_cmd_e           cmd_q;
  logic [csec_pkg::WordW-1:0]    data_q;
  logic [csec_pkg::CheckW-1:0]   rcv_q;
  logic                          out_valid_q;
  csec_pkg::csec_result_t        out_q;
  csec_pkg::csec_result_t        result_d;
  logic                          s1_advance;
  logic                          in_accept;

  // Check-row registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < csec_pkg::CfgIndexW'(csec_pkg::RowCount))) begin
      rows_q[cfg_index_i[csec_pkg::RowIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Handshake: stage one moves on whenever the result register is free or
  // being emptied.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= csec_pkg::csec_cmd_e'(cmd_i);
      data_q <= data_in_i;
      rcv_q  <= received_check_i;
    end
  end

  // Encode / check datapath.
  csec_core #(
    .PARITY_BITS (PARITY_BITS),
    .DATA_BITS   (DATA_BITS)
  ) u_core (
    .rows_i   (rows_q),
    .cmd_i    (cmd_q),
    .data_i   (data_q),
    .rcv_i    (rcv_q),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q.data_out;
  assign check_out_o = out_q.check_out;
  assign syndrome_o  = out_q.syndrome;
  assign status_o    = out_q.status;

  // Assertions.
  a_clean_zero_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == csec_pkg::STATUS_CLEAN) |-> out_q.syndrome == '0)
    else $error("clean result with nonzero syndrome");

  a_fixed_has_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != csec_pkg::STATUS_CLEAN) |-> out_q.syndrome != '0)
    else $error("error status with zero syndrome");

  a_syn_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.syndrome & ~CheckMask) == '0) &&
                    ((out_q.check_out & ~CheckMask) == '0))
    else $error("check bits set above the configured check width");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost from the input register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled while a stage is empty");

endmodule
